// ===== hw/rtl/spl_pkg.sv =====
// shared constants, types and a helper function of the stereo peak level meter
package spl_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int LOG_FRAC_BITS_DEF = 16;
    localparam int MANT_BITS         = 30;
    localparam int TARGET_BITS       = 14;
    localparam int LEVEL_BITS        = 16;
    localparam int SILENT_FLOOR      = -29184;

    typedef enum logic [2:0] {
        ST_TRACK,
        ST_MERGE,
        ST_LOG,
        ST_SCALE,
        ST_EMIT
    } t_meter_state;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE
    } t_log_state;

    typedef struct packed {
        logic en;
        logic clear;
    } t_lane_ctrl;

    // elaboration-time log2 with frac_bits fraction bits, same squaring scheme as the log unit
    function automatic logic [63:0] log2_const(input logic [63:0] x, input int frac_bits);
        logic [63:0] m;
        logic [63:0] frac;
        int          e;
        e = 0;
        for (int i = 0; i < 31; i++) begin
            if ((x >> (i + 1)) != 64'd0) begin
                e = i + 1;
            end
        end
        m    = x << (MANT_BITS - e);
        frac = '0;
        for (int i = 0; i < frac_bits; i++) begin
            m    = (m * m) >> MANT_BITS;
            frac = frac << 1;
            if (m >= (64'd2 << MANT_BITS)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(e) << frac_bits) | frac;
    endfunction

endpackage

// ===== hw/rtl/spl_lane.sv =====
// one channel lane: running minimum and maximum of the samples
module spl_lane import spl_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_peak_high,
    output logic signed [SAMPLE_BITS-1:0] o_peak_low
);

    localparam logic signed [SAMPLE_BITS-1:0] HIGH_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] LOW_INIT  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] r_high, n_high;
    logic signed [SAMPLE_BITS-1:0] r_low, n_low;

    always_comb begin
        n_high = r_high;
        n_low  = r_low;
        if (i_ctrl.clear) begin
            n_high = HIGH_INIT;
            n_low  = LOW_INIT;
        end else if (i_ctrl.en) begin
            if (i_sample > r_high) begin
                n_high = i_sample;
            end
            if (i_sample < r_low) begin
                n_low = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= HIGH_INIT;
            r_low  <= LOW_INIT;
        end else begin
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

    assign o_peak_high = r_high;
    assign o_peak_low  = r_low;

endmodule

// ===== hw/rtl/spl_log2.sv =====
// iterative log2 unit: shift normalize, then one mantissa squaring per fraction bit
module spl_log2 import spl_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [SAMPLE_BITS-1:0]                       i_x,
    output logic                                         o_done,
    output logic [$clog2(SAMPLE_BITS)+LOG_FRAC_BITS-1:0] o_log
);

    localparam int EW = $clog2(SAMPLE_BITS);
    localparam int CW = $clog2(LOG_FRAC_BITS);
    localparam int MW = MANT_BITS + 1;

    t_log_state r_state, n_state;

    logic [SAMPLE_BITS-1:0]   r_x;
    logic [EW-1:0]            r_e;
    logic [MW-1:0]            r_m;
    logic [LOG_FRAC_BITS-1:0] r_frac;
    logic [CW-1:0]            r_cnt;
    logic                     r_done;

    logic                     w_norm_shift;
    logic                     w_norm_load;
    logic                     w_sq_step;
    logic                     w_last_iter;
    logic [2*MW-1:0]          w_sq;
    logic [MW:0]              w_sq_top;

    assign w_last_iter = (r_cnt == CW'(LOG_FRAC_BITS - 1));
    assign w_sq        = (2*MW)'(r_m) * (2*MW)'(r_m);
    assign w_sq_top    = w_sq[MANT_BITS+MW:MANT_BITS];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LG_IDLE: begin
                if (i_start) begin
                    n_state = LG_NORM;
                end
            end
            LG_NORM: begin
                if (r_x[SAMPLE_BITS-1]) begin
                    n_state = LG_SQUARE;
                end
            end
            LG_SQUARE: begin
                if (w_last_iter) begin
                    n_state = LG_IDLE;
                end
            end
            default: n_state = LG_IDLE;
        endcase
    end

    always_comb begin
        w_norm_shift = 1'b0;
        w_norm_load  = 1'b0;
        w_sq_step    = 1'b0;
        unique case (r_state)
            LG_IDLE:   ;
            LG_NORM: begin
                w_norm_shift = !r_x[SAMPLE_BITS-1];
                w_norm_load  = r_x[SAMPLE_BITS-1];
            end
            LG_SQUARE: w_sq_step = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= w_sq_step && w_last_iter;
            if (w_norm_load) begin
                r_cnt <= '0;
            end else if (w_sq_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LG_IDLE && i_start) begin
            r_x <= i_x;
            r_e <= EW'(SAMPLE_BITS - 1);
        end else if (w_norm_shift) begin
            r_x <= {r_x[SAMPLE_BITS-2:0], 1'b0};
            r_e <= r_e - 1'b1;
        end
        if (w_norm_load) begin
            r_m    <= MW'(r_x) << (MW - SAMPLE_BITS);
            r_frac <= '0;
        end else if (w_sq_step) begin
            if (w_sq_top[MW]) begin
                r_m    <= w_sq_top[MW:1];
                r_frac <= {r_frac[LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
                r_m    <= w_sq_top[MW-1:0];
                r_frac <= {r_frac[LOG_FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_e, r_frac};

endmodule

// ===== hw/rtl/stereo_peak_level_meter_unit.sv =====
// Stereo peak level meter. Sample pairs are taken one per cycle while the meter tracks; each
// channel lane keeps its own minimum and maximum. After the pair marked tlast the input stalls
// while the merge stage picks the larger peak ratio and the shared log2 unit runs: the merge
// step, the normalize shifts, one squaring per fraction bit (one 31x31 square each), then the
// scale step, the target subtraction and the output register. An all-zero block goes from the
// merge straight to the output as the silent floor code; either result also waits while the
// previous level still sits in the output register.
// The result waits in an output register; the next block can be tracked meanwhile. level is
// 6*log2 of the peak ratio minus level_target, in 1/256 steps, saturated to 16 bits.
module stereo_peak_level_meter_unit import spl_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [TARGET_BITS-1:0]                   i_cfg_data,    // level_target
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // left_sample, right_sample
    input  logic                                     s_axis_tlast,  // last_pair
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [LEVEL_BITS-1:0]                    m_axis_tdata,  // level
    output logic                                     m_axis_tuser   // silent
);

    localparam int SB  = SAMPLE_BITS;
    localparam int EW  = $clog2(SAMPLE_BITS);
    localparam int LW  = EW + LOG_FRAC_BITS;
    localparam int PW  = LW + 12;
    localparam int SCW = PW - LOG_FRAC_BITS;
    localparam int SW  = ((SCW > LEVEL_BITS) ? SCW : LEVEL_BITS) + 1;

    localparam logic [LW-1:0] LOG_POS =
        LW'(log2_const(64'(2**(SB-1) - 1), LOG_FRAC_BITS));
    localparam logic [LW-1:0] LOG_NEG =
        LW'(log2_const(64'(2**(SB-1)), LOG_FRAC_BITS));
    localparam logic signed [SW-1:0] LVL_MAX = SW'(2**(LEVEL_BITS-1) - 1);
    localparam logic signed [SW-1:0] LVL_MIN = -SW'(2**(LEVEL_BITS-1));
    localparam logic [LEVEL_BITS-1:0] FLOOR_CODE = LEVEL_BITS'(SILENT_FLOOR);

    t_meter_state r_state, n_state;

    logic signed [TARGET_BITS-1:0] r_target;
    logic                          r_use_neg;
    logic                          r_silent;
    logic signed [SCW-1:0]         r_scaled;
    logic                          r_out_valid;
    logic [LEVEL_BITS-1:0]         r_level;
    logic                          r_out_silent;

    t_lane_ctrl                    w_lane_ctrl;
    logic                          w_beat;
    logic                          w_out_free;
    logic                          w_log_start;
    logic                          w_load_out;
    logic                          w_cap_merge;
    logic                          w_cap_scale;

    logic signed [SB-1:0] w_lh, w_ll, w_rh, w_rl;
    logic signed [SB-1:0] w_top, w_bot;
    logic [SB-1:0]        w_pnum, w_nnum, w_num;
    logic [2*SB-1:0]      w_pos_term, w_neg_term;
    logic                 w_top_pos, w_pick_pos, w_merge_silent;

    logic                 w_log_done;
    logic [LW-1:0]        w_ln;
    logic signed [LW:0]   w_d;
    logic signed [PW-1:0] w_d_ext, w_prod;
    logic signed [SW-1:0] w_sum;

    assign w_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    spl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_lane_ctrl),
        .i_sample    (s_axis_tdata[SB-1:0]),
        .o_peak_high (w_lh),
        .o_peak_low  (w_ll)
    );

    spl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_lane_ctrl),
        .i_sample    (s_axis_tdata[2*SB-1:SB]),
        .o_peak_high (w_rh),
        .o_peak_low  (w_rl)
    );

    // merge of the lanes
    assign w_top      = (w_lh > w_rh) ? w_lh : w_rh;
    assign w_bot      = (w_ll < w_rl) ? w_ll : w_rl;
    assign w_top_pos  = !w_top[SB-1] && (w_top != '0);
    assign w_pnum     = w_top;
    assign w_nnum     = w_bot[SB-1] ? (~w_bot + 1'b1) : w_bot;
    assign w_pos_term = (2*SB)'(w_pnum) << (SB - 1);
    assign w_neg_term = ((2*SB)'(w_nnum) << (SB - 1)) - (2*SB)'(w_nnum);
    assign w_pick_pos = w_top_pos && (w_pos_term >= w_neg_term);
    assign w_merge_silent = !w_pick_pos && (w_nnum == '0);
    assign w_num      = w_pick_pos ? w_pnum : w_nnum;

    spl_log2 #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_log_start),
        .i_x     (w_num),
        .o_done  (w_log_done),
        .o_log   (w_ln)
    );

    // 6*256 = 1536, floor through the arithmetic shift
    assign w_d     = $signed({1'b0, w_ln}) - $signed({1'b0, (r_use_neg ? LOG_NEG : LOG_POS)});
    assign w_d_ext = PW'(w_d);
    assign w_prod  = (w_d_ext <<< 10) + (w_d_ext <<< 9);
    assign w_sum   = SW'(r_scaled) - SW'(r_target);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_TRACK: begin
                if (w_beat && s_axis_tlast) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: n_state = w_merge_silent ? ST_EMIT : ST_LOG;
            ST_LOG: begin
                if (w_log_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_TRACK;
                end
            end
            default: n_state = ST_TRACK;
        endcase
    end

    always_comb begin
        s_axis_tready     = 1'b0;
        w_lane_ctrl.en    = 1'b0;
        w_lane_ctrl.clear = 1'b0;
        w_log_start       = 1'b0;
        w_cap_merge       = 1'b0;
        w_cap_scale       = 1'b0;
        w_load_out        = 1'b0;
        unique case (r_state)
            ST_TRACK: begin
                s_axis_tready  = 1'b1;
                w_lane_ctrl.en = s_axis_tvalid;
            end
            ST_MERGE: begin
                w_lane_ctrl.clear = 1'b1;
                w_cap_merge       = 1'b1;
                w_log_start       = !w_merge_silent;
            end
            ST_LOG:   ;
            ST_SCALE: w_cap_scale = 1'b1;
            ST_EMIT:  w_load_out  = w_out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TRACK;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap_merge) begin
            r_use_neg <= !w_pick_pos;
            r_silent  <= w_merge_silent;
        end
        if (w_cap_scale) begin
            r_scaled <= w_prod[PW-1:LOG_FRAC_BITS];
        end
        if (w_load_out) begin
            r_out_silent <= r_silent;
            if (r_silent) begin
                r_level <= FLOOR_CODE;
            end else if (w_sum > LVL_MAX) begin
                r_level <= LVL_MAX[LEVEL_BITS-1:0];
            end else if (w_sum < LVL_MIN) begin
                r_level <= LVL_MIN[LEVEL_BITS-1:0];
            end else begin
                r_level <= w_sum[LEVEL_BITS-1:0];
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_level;
    assign m_axis_tuser  = r_out_silent;

endmodule

// ===== tb/sv/tb.sv =====
// testbench of the stereo peak level meter: level predictor, stream drivers and result checks
`timescale 1ns / 100ps

module tb;
    import spl_pkg::*;

    localparam int      CLK_PERIOD   = 4;
    localparam longint  FULL_POS     = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint  FULL_NEG     = longint'(1) <<< (SAMPLE_BITS_DEF - 1);
    localparam longint  LEVEL_SCALE  = 6 * 256;
    localparam int      DRAIN_CYCLES = SAMPLE_BITS_DEF + LOG_FRAC_BITS_DEF + 8;
    localparam int      IDLE_LIMIT   = 4000;
    localparam int      RANDOM_PAIRS = 1450;
    localparam int      PHASE_PAIRS  = 160;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0] level;
        logic                         silent;
    } t_level_result;

    typedef enum int {
        MIX_FULL,
        MIX_QUIET,
        MIX_NEG,
        MIX_POS,
        MIX_ZERO,
        MIX_EDGE
    } t_block_mix;

    class level_scoreboard;
        logic signed [SAMPLE_BITS_DEF-1:0] l_hi, l_lo, r_hi, r_lo;
        logic signed [TARGET_BITS-1:0]     target;
        t_level_result                     expected_levels[$];
        int errors, pairs, results, silent_results, settings;

        function new();
            target = '0;
            clear_peaks();
        endfunction

        function void clear_peaks();
            l_hi = SAMPLE_BITS_DEF'(-FULL_NEG);
            r_hi = SAMPLE_BITS_DEF'(-FULL_NEG);
            l_lo = SAMPLE_BITS_DEF'(FULL_POS);
            r_lo = SAMPLE_BITS_DEF'(FULL_POS);
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // integer part from the leading one, fraction by repeated squaring of the mantissa
        function longint unsigned peak_log2(longint unsigned x);
            int unsigned     e;
            longint unsigned m;
            longint unsigned frac;
            e = 0;
            while (e < 31 && (x >> (e + 1)) != 0) e++;
            m    = x << (MANT_BITS - e);
            frac = 0;
            for (int i = 0; i < LOG_FRAC_BITS_DEF; i++) begin
                m    = (m * m) >> MANT_BITS;
                frac = frac << 1;
                if (m >= (64'd2 << MANT_BITS)) begin
                    m    = m >> 1;
                    frac = frac | 64'd1;
                end
            end
            return (longint'(e) << LOG_FRAC_BITS_DEF) | frac;
        endfunction

        function void note_pair(logic signed [SAMPLE_BITS_DEF-1:0] l,
                                logic signed [SAMPLE_BITS_DEF-1:0] r, bit last);
            longint        top, bot, pnum, nnum, num, den, d, mag, lvl;
            t_level_result res;
            pairs++;
            if (l > l_hi) l_hi = l;
            if (l < l_lo) l_lo = l;
            if (r > r_hi) r_hi = r;
            if (r < r_lo) r_lo = r;
            if (!last) return;
            top  = longint'((l_hi > r_hi) ? l_hi : r_hi);
            bot  = longint'((l_lo < r_lo) ? l_lo : r_lo);
            pnum = top;
            nnum = (bot < 0) ? -bot : bot;
            num  = 1;
            den  = 1;
            res.silent = 1'b0;
            if (pnum > 0 && pnum * FULL_NEG >= nnum * FULL_POS) begin
                num = pnum;
                den = FULL_POS;
            end else if (nnum > 0) begin
                num = nnum;
                den = FULL_NEG;
            end else begin
                res.silent = 1'b1;
            end
            if (res.silent) begin
                lvl = longint'(SILENT_FLOOR);
                silent_results++;
            end else begin
                d = longint'(peak_log2(num)) - longint'(peak_log2(den));
                if (d >= 0) begin
                    lvl = (d * LEVEL_SCALE) >>> LOG_FRAC_BITS_DEF;
                end else begin
                    mag = -d * LEVEL_SCALE;
                    lvl = -((mag + (longint'(1) <<< LOG_FRAC_BITS_DEF) - 1) >>> LOG_FRAC_BITS_DEF);
                end
                lvl = lvl - target;
                if (lvl > 32767) lvl = 32767;
                if (lvl < -32768) lvl = -32768;
            end
            res.level = lvl[LEVEL_BITS-1:0];
            expected_levels.push_back(res);
            clear_peaks();
        endfunction

        function void check_result(logic [LEVEL_BITS-1:0] level, logic silent);
            t_level_result exp_res;
            results++;
            if (expected_levels.size() == 0) begin
                $error("unexpected level beat: level %0d silent %0b", $signed(level), silent);
                errors++;
                return;
            end
            exp_res = expected_levels.pop_front();
            if (level !== exp_res.level) begin
                $error("level mismatch: expected %0d, got %0d", exp_res.level, $signed(level));
                errors++;
            end
            if (silent !== exp_res.silent) begin
                $error("silent mismatch: expected %0b, got %0b", exp_res.silent, silent);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [TARGET_BITS-1:0]  i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [31:0]             s_axis_tdata;   // left_sample, right_sample
    logic                    s_axis_tlast;   // last_pair
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [LEVEL_BITS-1:0]   m_axis_tdata;   // level
    logic                    m_axis_tuser;   // silent

    level_scoreboard sb = new();
    bit              steady_sender;
    int              random_pairs;
    int              idle_cycles;

    stereo_peak_level_meter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] draw_sample(t_block_mix mix);
        int v;
        int span;
        span = 1 << $urandom_range(0, 15);
        case (mix)
            MIX_FULL:  v = $urandom_range(0, 65535);
            MIX_QUIET: v = int'($urandom_range(0, 600)) - 300;
            MIX_NEG:   v = -int'($urandom_range(1, span));
            MIX_POS:   v = $urandom_range(0, span - 1);
            MIX_ZERO:  v = 0;
            default: begin
                case ($urandom_range(0, 6))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = -32767;
                    3:       v = 32766;
                    4:       v = 1;
                    5:       v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    function automatic t_block_mix pick_mix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return MIX_FULL;
        if (r < 50) return MIX_QUIET;
        if (r < 65) return MIX_NEG;
        if (r < 80) return MIX_POS;
        if (r < 85) return MIX_ZERO;
        return MIX_EDGE;
    endfunction

    task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                             input bit last);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {r, l};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_block(input int len);
        t_block_mix mix;
        mix = pick_mix();
        steady_sender = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            send_pair(draw_sample(mix), draw_sample(mix), i == len - 1);
            random_pairs++;
        end
    endtask

    // waits until every level is out and the log unit has settled
    task automatic drain_meter();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic signed [TARGET_BITS-1:0] value);
        drain_meter();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // input, config and level monitors
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_pair(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            sb.target = i_cfg_data;
            sb.settings++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls
    initial begin
        int run;
        int hold;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic signed [TARGET_BITS-1:0] targets[6];
        logic signed [TARGET_BITS-1:0] next_target;
        int phase;
        int phase_pairs;
        int len;
        int r;
        targets = '{-14'sd6144, 14'sd6144, -14'sd1, 14'sd5461, -14'sd5462, 14'sd0};
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        steady_sender = 1'b0;
        random_pairs  = 0;
        idle_cycles   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // silence, full scale on each side, ties, single-sign blocks, tracker reset
        send_pair(0, 0, 1);
        send_pair(32767, 0, 1);
        send_pair(0, -32768, 1);
        send_pair(32767, -32768, 1);
        send_pair(-32768, 32767, 1);
        send_pair(-1, -1, 1);
        send_pair(1, 0, 1);
        send_pair(0, 0, 0);
        send_pair(0, 0, 1);
        send_pair(-5, -700, 0);
        send_pair(-300, -2, 1);
        send_pair(3, 900, 0);
        send_pair(40, 7, 1);
        send_pair(16'sh5555, 16'shAAAA, 0);
        send_pair(16'shAAAA, 16'sh5555, 1);
        send_pair(16384, -16384, 1);
        send_pair(-16385, 16384, 1);
        send_pair(0, 0, 0);
        send_pair(-32768, -32768, 0);
        send_pair(0, 0, 1);

        phase = 0;
        while (random_pairs < RANDOM_PAIRS) begin
            if (phase < 6) next_target = targets[phase];
            else next_target = TARGET_BITS'(int'($urandom_range(0, 12288)) - 6144);
            write_target(next_target);
            phase++;
            phase_pairs = random_pairs;
            while (random_pairs - phase_pairs < PHASE_PAIRS && random_pairs < RANDOM_PAIRS) begin
                r = $urandom_range(0, 99);
                if (r < 70) len = $urandom_range(1, 6);
                else if (r < 95) len = $urandom_range(7, 20);
                else len = $urandom_range(21, 60);
                send_block(len);
            end
        end

        drain_meter();
        $display("%0d sample pairs, %0d levels checked (%0d silent), %0d target settings",
                 sb.pairs, sb.results, sb.silent_results, sb.settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
